// ===== sv/rv_exu_pkg.sv =====
// rv_exu_pkg: operation codes, item classes and the transaction type shared by
// the execute unit modules
// no dependencies
package rv_exu_pkg;

	localparam int XLEN = 32;
	localparam int OPW = 5;

	// operation codes
	localparam logic [OPW-1:0] OP_OR     = 5'd0;
	localparam logic [OPW-1:0] OP_AND    = 5'd1;
	localparam logic [OPW-1:0] OP_XOR    = 5'd2;
	localparam logic [OPW-1:0] OP_ADD    = 5'd3;
	localparam logic [OPW-1:0] OP_SUB    = 5'd4;
	localparam logic [OPW-1:0] OP_SLL    = 5'd5;
	localparam logic [OPW-1:0] OP_SRL    = 5'd6;
	localparam logic [OPW-1:0] OP_SRA    = 5'd7;
	localparam logic [OPW-1:0] OP_MUL    = 5'd8;
	localparam logic [OPW-1:0] OP_MULH   = 5'd9;
	localparam logic [OPW-1:0] OP_MULHSU = 5'd10;
	localparam logic [OPW-1:0] OP_MULHU  = 5'd11;
	localparam logic [OPW-1:0] OP_DIV    = 5'd12;
	localparam logic [OPW-1:0] OP_DIVU   = 5'd13;
	localparam logic [OPW-1:0] OP_REM    = 5'd14;
	localparam logic [OPW-1:0] OP_REMU   = 5'd15;
	localparam logic [OPW-1:0] OP_SLT    = 5'd16;
	localparam logic [OPW-1:0] OP_SLTU   = 5'd17;
	localparam logic [OPW-1:0] OP_PCADD  = 5'd18;
	localparam logic [OPW-1:0] OP_JALR   = 5'd19;
	localparam logic [OPW-1:0] OP_BEQ    = 5'd20;
	localparam logic [OPW-1:0] OP_BNE    = 5'd21;
	localparam logic [OPW-1:0] OP_BLT    = 5'd22;
	localparam logic [OPW-1:0] OP_BLTU   = 5'd23;
	localparam logic [OPW-1:0] OP_BGE    = 5'd24;
	localparam logic [OPW-1:0] OP_BGEU   = 5'd25;

	localparam logic [XLEN-1:0] JUMP_MASK = 32'hFFFF_FFFE;

	// item classes
	typedef enum logic [1:0] {
		CLS_ALU,
		CLS_MUL,
		CLS_DIV,
		CLS_NONE
	} cls_t;

	// one classified transaction
	typedef struct packed {
		cls_t            cls;
		logic [OPW-1:0]  op;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic [XLEN-1:0] pc;
	} item_t;

endpackage

// ===== sv/rv_exu_front.sv =====
// rv_exu_front: input register stage that accepts and classifies transactions
// depends on rv_exu_pkg
module rv_exu_front
	import rv_exu_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [OPW-1:0]  action,
	input  logic [XLEN-1:0] operand_a,
	input  logic [XLEN-1:0] operand_b,
	input  logic [XLEN-1:0] program_counter,
	input  logic            q_full,
	output logic            q_push,
	output item_t           q_item
);

	logic  v_s1;
	item_t item_s1;
	logic  load;
	cls_t  cls;

	// classify by operation code
	always_comb begin
		case (action)
			OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU: cls = CLS_MUL;
			OP_DIV, OP_DIVU, OP_REM, OP_REMU:     cls = CLS_DIV;
			default: begin
				if (action <= OP_BGEU)
					cls = CLS_ALU;
				else
					cls = CLS_NONE;
			end
		endcase
	end

	assign full   = v_s1 && q_full;
	assign load   = push && !full;
	assign q_push = v_s1 && !q_full;
	assign q_item = item_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (load)
			v_s1 <= 1'b1;
		else if (q_push)
			v_s1 <= 1'b0;
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.cls <= cls;
			item_s1.op  <= action;
			item_s1.a   <= operand_a;
			item_s1.b   <= operand_b;
			item_s1.pc  <= program_counter;
		end
	end

endmodule

// ===== sv/rv_exu_queue.sv =====
// rv_exu_queue: short transaction queue between the front and back parts
// depends on rv_exu_pkg
module rv_exu_queue
	import rv_exu_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	input  logic  pop,
	output item_t rdata,
	output logic  full,
	output logic  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

// ===== sv/rv_exu_back.sv =====
// rv_exu_back: execute pipeline, alu and multiply in the first stage, one
// quotient bit per stage for divide, then sign fix-up into the result register
// depends on rv_exu_pkg
module rv_exu_back
	import rv_exu_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  item_t           q_item,
	output logic            q_pop,
	output logic            empty,
	input  logic            pop,
	output logic [XLEN-1:0] result
);

	typedef struct packed {
		logic [OPW-1:0]  op;
		logic [XLEN-1:0] res;
		logic [XLEN-1:0] r;
		logic [XLEN-1:0] q;
		logic [XLEN-1:0] d;
		logic            neg_q;
		logic            neg_r;
	} dv_t;

	logic              adv;
	logic              ev_s0;
	dv_t               ex_s0;
	logic [2*XLEN+1:0] prod_s0;
	logic              dv_v_s [XLEN];
	dv_t               dv_s   [XLEN];
	logic              ov_s;
	logic [XLEN-1:0]   out_s;

	logic [XLEN-1:0]   a;
	logic [XLEN-1:0]   b;
	logic [4:0]        sh;
	logic [XLEN-1:0]   alu_res;
	logic              lt_s;
	logic              lt_u;
	logic              sgn;
	logic              a_neg;
	logic              b_neg;
	logic [XLEN:0]     ma;
	logic [XLEN:0]     mb;
	logic [2*XLEN+1:0] prod;
	dv_t               first;
	dv_t               last;
	logic [XLEN-1:0]   fin;

	// one restoring divide step
	function automatic dv_t div_step(input dv_t x);
		dv_t         y;
		logic [XLEN:0] t;
		logic [XLEN:0] diff;
		y    = x;
		t    = {x.r, x.q[XLEN-1]};
		diff = t - {1'b0, x.d};
		if (!diff[XLEN]) begin
			y.r = diff[XLEN-1:0];
			y.q = {x.q[XLEN-2:0], 1'b1};
		end else begin
			y.r = t[XLEN-1:0];
			y.q = {x.q[XLEN-2:0], 1'b0};
		end
		return y;
	endfunction

	assign adv   = !ov_s || pop;
	assign q_pop = adv && !q_empty;
	assign empty = !ov_s;
	assign result = out_s;

	assign a  = q_item.a;
	assign b  = q_item.b;
	assign sh = b[4:0];
	assign lt_s = $signed(a) < $signed(b);
	assign lt_u = a < b;

	// simple operations
	always_comb begin
		case (q_item.op)
			OP_OR:    alu_res = a | b;
			OP_AND:   alu_res = a & b;
			OP_XOR:   alu_res = a ^ b;
			OP_ADD:   alu_res = a + b;
			OP_SUB:   alu_res = a - b;
			OP_SLL:   alu_res = a << sh;
			OP_SRL:   alu_res = a >> sh;
			OP_SRA:   alu_res = XLEN'($signed(a) >>> sh);
			OP_SLT:   alu_res = {{(XLEN-1){1'b0}}, lt_s};
			OP_SLTU:  alu_res = {{(XLEN-1){1'b0}}, lt_u};
			OP_PCADD: alu_res = q_item.pc + b;
			OP_JALR:  alu_res = (a + b) & JUMP_MASK;
			OP_BEQ:   alu_res = {{(XLEN-1){1'b0}}, a == b};
			OP_BNE:   alu_res = {{(XLEN-1){1'b0}}, a != b};
			OP_BLT:   alu_res = {{(XLEN-1){1'b0}}, lt_s};
			OP_BLTU:  alu_res = {{(XLEN-1){1'b0}}, lt_u};
			OP_BGE:   alu_res = {{(XLEN-1){1'b0}}, !lt_s};
			OP_BGEU:  alu_res = {{(XLEN-1){1'b0}}, !lt_u};
			default:  alu_res = '0;
		endcase
	end

	// multiply operands, sign extended where the operation is signed
	always_comb begin
		ma = {1'b0, a};
		mb = {1'b0, b};
		case (q_item.op)
			OP_MULH: begin
				ma = {a[XLEN-1], a};
				mb = {b[XLEN-1], b};
			end
			OP_MULHSU: ma = {a[XLEN-1], a};
			default: ;
		endcase
	end
	assign prod = $signed(ma) * $signed(mb);

	// divide setup: magnitudes and result signs
	assign sgn   = (q_item.op == OP_DIV) || (q_item.op == OP_REM);
	assign a_neg = sgn && a[XLEN-1];
	assign b_neg = sgn && b[XLEN-1];

	// first stage valid and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ev_s0 <= 1'b0;
		else if (adv)
			ev_s0 <= !q_empty && (q_item.cls != CLS_NONE || 1'b1);
	end

	// first stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s0.op    <= q_item.op;
			ex_s0.res   <= alu_res;
			ex_s0.r     <= '0;
			ex_s0.q     <= a_neg ? -a : a;
			ex_s0.d     <= b_neg ? -b : b;
			ex_s0.neg_q <= (a_neg ^ b_neg) && (b != '0);
			ex_s0.neg_r <= a_neg;
			prod_s0     <= prod;
		end
	end

	// product word select joins the first divide step
	always_comb begin
		first = ex_s0;
		case (ex_s0.op)
			OP_MUL:                       first.res = prod_s0[XLEN-1:0];
			OP_MULH, OP_MULHSU, OP_MULHU: first.res = prod_s0[2*XLEN-1:XLEN];
			default: ;
		endcase
	end

	// divide stages valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < XLEN; i++)
				dv_v_s[i] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= ev_s0;
			for (int i = 1; i < XLEN; i++)
				dv_v_s[i] <= dv_v_s[i-1];
		end
	end

	// divide stages payload
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= div_step(first);
			for (int i = 1; i < XLEN; i++)
				dv_s[i] <= div_step(dv_s[i-1]);
		end
	end

	// sign fix-up and final select
	assign last = dv_s[XLEN-1];
	always_comb begin
		case (last.op)
			OP_DIV, OP_DIVU: fin = last.neg_q ? -last.q : last.q;
			OP_REM, OP_REMU: fin = last.neg_r ? -last.r : last.r;
			default:         fin = last.res;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_s <= 1'b0;
		else if (adv)
			ov_s <= dv_v_s[XLEN-1];
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_s <= fin;
	end

endmodule

// ===== sv/rv32im_execute_unit.sv =====
// rv32im_execute_unit: top level, front stage, transaction queue and execute
// pipeline; depends on rv_exu_pkg, rv_exu_front, rv_exu_queue, rv_exu_back
//
// RV32IM execute unit. One transaction is accepted per cycle while full is low
// and gives one 32-bit result; results leave in order. Every operation takes the
// same path: one front register, the queue, a first execute stage with the alu
// and a 33x33 multiplier, 32 divide stages that each resolve one quotient bit,
// and the result register. The queue holds QUEUE_DEPTH transactions; when the
// result is not popped the execute pipeline holds still and the queue and front
// fill before full rises.
module rv32im_execute_unit
	import rv_exu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [OPW-1:0]  action,
	input  logic [XLEN-1:0] operand_a,
	input  logic [XLEN-1:0] operand_b,
	input  logic [XLEN-1:0] program_counter,
	output logic            empty,
	input  logic            pop,
	output logic [XLEN-1:0] result
);

	logic  q_push;
	logic  q_pop;
	logic  q_full;
	logic  q_empty;
	item_t q_wdata;
	item_t q_rdata;

	// front: accept and classify
	rv_exu_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.action          (action),
		.operand_a       (operand_a),
		.operand_b       (operand_b),
		.program_counter (program_counter),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_item          (q_wdata)
	);

	// queue between front and back
	rv_exu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: execute pipeline
	rv_exu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	// queue is written only with room and read only with data
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("queue written while full");
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("queue read while empty");
	// front backs up only when the queue is full
	assert property (@(posedge clk) disable iff (!arst_n) full |-> q_full)
		else $error("front full with queue room");

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the rv32im execute unit, directed and random transactions
// with an arithmetic predictor checked result by result in order
// depends on rv_exu_pkg and rv32im_execute_unit
module testbench
	import rv_exu_pkg::*;
();

	logic            clk;
	logic            arst_n;
	logic            push;
	logic            full;
	logic [OPW-1:0]  action;
	logic [XLEN-1:0] operand_a;
	logic [XLEN-1:0] operand_b;
	logic [XLEN-1:0] program_counter;
	logic            empty;
	logic            pop;
	logic [XLEN-1:0] result;

	logic [XLEN-1:0] pending_results[$];
	int              error_count;
	bit              sender_idle_bursts;
	bit              receiver_idle_bursts;

	rv32im_execute_unit uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .action(action),
		.operand_a(operand_a), .operand_b(operand_b), .program_counter(program_counter),
		.empty(empty), .pop(pop), .result(result)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// signed division and remainder per the isa, including zero divisor and overflow
	function automatic logic [XLEN-1:0] signed_quotient(logic [XLEN-1:0] a, logic [XLEN-1:0] b,
			bit want_rem);
		logic [XLEN-1:0] mag_a;
		logic [XLEN-1:0] mag_b;
		logic [XLEN-1:0] q;
		logic [XLEN-1:0] r;
		mag_a = a[XLEN-1] ? -a : a;
		mag_b = b[XLEN-1] ? -b : b;
		if (b == '0) begin
			return want_rem ? a : '1;
		end
		q = mag_a / mag_b;
		r = mag_a % mag_b;
		if (want_rem) begin
			return a[XLEN-1] ? -r : r;
		end
		return (a[XLEN-1] ^ b[XLEN-1]) ? -q : q;
	endfunction

	// expected execute result
	function automatic logic [XLEN-1:0] execute_result(logic [OPW-1:0] op, logic [XLEN-1:0] a,
			logic [XLEN-1:0] b, logic [XLEN-1:0] pc);
		logic [4:0]  sh;
		logic [63:0] prod;
		bit          lt_s;
		bit          lt_u;
		sh = b[4:0];
		lt_s = $signed(a) < $signed(b);
		lt_u = a < b;
		case (op)
			OP_OR:     return a | b;
			OP_AND:    return a & b;
			OP_XOR:    return a ^ b;
			OP_ADD:    return a + b;
			OP_SUB:    return a - b;
			OP_SLL:    return a << sh;
			OP_SRL:    return a >> sh;
			OP_SRA:    return $signed(a) >>> sh;
			OP_MUL:    return a * b;
			OP_MULH: begin
				prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
				return prod[63:32];
			end
			OP_MULHSU: begin
				prod = {{32{a[31]}}, a} * {32'd0, b};
				return prod[63:32];
			end
			OP_MULHU: begin
				prod = {32'd0, a} * {32'd0, b};
				return prod[63:32];
			end
			OP_DIV:    return signed_quotient(a, b, 1'b0);
			OP_DIVU:   return (b == '0) ? '1 : a / b;
			OP_REM:    return signed_quotient(a, b, 1'b1);
			OP_REMU:   return (b == '0) ? a : a % b;
			OP_SLT:    return XLEN'(lt_s);
			OP_SLTU:   return XLEN'(lt_u);
			OP_PCADD:  return pc + b;
			OP_JALR:   return (a + b) & JUMP_MASK;
			OP_BEQ:    return XLEN'(a == b);
			OP_BNE:    return XLEN'(a != b);
			OP_BLT:    return XLEN'(lt_s);
			OP_BLTU:   return XLEN'(lt_u);
			OP_BGE:    return XLEN'(!lt_s);
			OP_BGEU:   return XLEN'(!lt_u);
			default:   return '0;
		endcase
	endfunction

	// send one transaction, with an optional idle burst before it
	task automatic send_op(logic [OPW-1:0] op, logic [XLEN-1:0] a, logic [XLEN-1:0] b,
			logic [XLEN-1:0] pc);
		int gap;
		if (sender_idle_bursts && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		action <= op;
		operand_a <= a;
		operand_b <= b;
		program_counter <= pc;
		@(posedge clk);
		while (full) @(posedge clk);
		pending_results.push_back(execute_result(op, a, b, pc));
		@(negedge clk);
	endtask

	task automatic stop_sending();
		push <= 1'b0;
	endtask

	function automatic logic [XLEN-1:0] random_operand();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return $urandom_range(0, 40);
			default: return $urandom;
		endcase
	endfunction

	// directed: every operation code with extreme operands, then divide overflow, zero divisors and an unused code
	task automatic test_directed();
		logic [OPW-1:0] op;
		for (int i = 0; i <= int'(OP_BGEU); i++) begin
			op = OPW'(i);
			send_op(op, 32'hFFFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFC);
		end
		send_op(OP_SRA, 32'h8000_0000, 32'hFFFF_FFE3, '0);
		send_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, '0);
		send_op(OP_REM, 32'h8000_0000, 32'hFFFF_FFFF, '0);
		send_op(OP_DIVU, 32'h1234_5678, '0, '0);
		send_op(OP_REMU, 32'h1234_5678, '0, '0);
		send_op(OP_DIV, 32'h8765_4321, '0, '0);
		send_op(5'd31, '1, '1, '1);
		stop_sending();
	endtask

	// pause until every result has arrived
	task automatic test_drain_pause();
		stop_sending();
		while (pending_results.size() != 0) @(negedge clk);
		send_op(OP_MULH, 32'h8000_0000, 32'h8000_0000, '0);
		stop_sending();
	endtask

	// random transactions over all codes, including the unused ones
	task automatic test_random(int count);
		logic [OPW-1:0] op;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 15) == 0) ? OPW'($urandom_range(26, 31))
				: OPW'($urandom_range(0, 25));
			send_op(op, random_operand(), random_operand(), $urandom);
		end
		stop_sending();
	endtask

	// result receiver with random stall bursts
	always begin
		@(negedge clk);
		if (receiver_idle_bursts && $urandom_range(0, 3) == 0) begin
			pop <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		pop <= 1'b1;
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("result 0x%08h with no transaction outstanding", result);
				error_count++;
			end else begin
				if (result !== pending_results[0]) begin
					$error("result expected 0x%08h actual 0x%08h", pending_results[0], result);
					error_count++;
				end
				void'(pending_results.pop_front());
			end
		end
	end

	// stimulus
	initial begin
		error_count = 0;
		sender_idle_bursts = 1'b1;
		receiver_idle_bursts = 1'b1;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		action = '0;
		operand_a = '0;
		operand_b = '0;
		program_counter = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_drain_pause();
		test_random(1700);
		sender_idle_bursts = 1'b0;
		receiver_idle_bursts = 1'b0;
		test_random(300);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// timeout
	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

endmodule
